>>> design/lmp_pkg.sv
// ----------------------------------------------------------------------------
// lmp_pkg
// Shared types and constants of the list-mode event word parser: result
// kinds, the result record, the push bundle between parser and result queue.
// ----------------------------------------------------------------------------
package lmp_pkg;

  // result kinds, carried on tuser
  typedef enum logic [2:0] {
    KIND_EVENT   = 3'd0,
    KIND_SAMPLE  = 3'd1,
    KIND_STATS   = 3'd2,
    KIND_BAD_HDR = 3'd3,
    KIND_BAD_EVT = 3'd4,
    KIND_EMPTY   = 3'd5
  } lmp_kind_t;

  // configuration register index (paddr bit 2)
  localparam logic REG_STATS_HEADER_LENGTH = 1'b0;

  // decode constants
  localparam logic [10:0] CRATE_STEP = 11'd100;
  localparam logic [11:0] MODULE_MAX = 12'd4095;
  localparam logic [15:0] ENERGY_SAT = 16'd16383;

  // result queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // tdata width: 131 payload bits padded to whole bytes
  localparam int TDATA_W = 136;

  // one result transaction
  typedef struct packed {
    lmp_kind_t   kind;
    logic [3:0]  channel;
    logic [11:0] module_res;
    logic [47:0] event_time;
    logic [15:0] cfd_time;
    logic [15:0] energy;
    logic [15:0] trace_length;
    logic        pileup;
    logic        saturated;
    logic        virtual_chan;
    logic [15:0] sample;
    logic        last;
  } lmp_result_t;

  // results produced by one accepted word (count is 0, 1 or 2)
  typedef struct packed {
    logic [1:0]  count;
    lmp_result_t first;
    lmp_result_t second;
  } lmp_push_t;

endpackage

>>> design/lmp_parser.sv
// ----------------------------------------------------------------------------
// lmp_parser
// Buffer and event framing state machine. Decodes each accepted word in the
// cycle it arrives and hands zero, one or two result records to the queue.
// ----------------------------------------------------------------------------
module lmp_parser
  import lmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [31:0] data_word,
  input  logic [4:0]  stats_header_length,
  output lmp_push_t   push
);

  typedef enum logic [6:0] {
    PH_LEN   = 7'b0000001,
    PH_MOD   = 7'b0000010,
    PH_HDR0  = 7'b0000100,
    PH_HDR   = 7'b0001000,
    PH_TRACE = 7'b0010000,
    PH_SKIP  = 7'b0100000,
    PH_DRAIN = 7'b1000000
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] buffer_words_left, buffer_words_left_next;
  logic [11:0] base_module, base_module_next;
  logic [4:0]  header_word_index, header_word_index_next;
  logic [4:0]  header_words, header_words_next;
  logic [11:0] event_words_left, event_words_left_next;
  logic [11:0] event_words, event_words_next;
  logic [31:0] header_first_word, header_first_word_next;
  logic [31:0] time_low_word, time_low_word_next;
  logic [31:0] time_cfd_word, time_cfd_word_next;
  logic [14:0] trace_words_left, trace_words_left_next;

  logic [31:0] words_dec;
  logic [4:0]  hl;
  logic [11:0] el;
  logic [14:0] tl_half;
  logic [15:0] len_sum;
  logic [5:0]  idx_inc;
  logic [14:0] trace_left_now;
  logic        hdr_stay;

  // event, stats and bad-length records
  function automatic lmp_result_t make_header(input logic [31:0] h, input lmp_kind_t kind,
                                              input logic detail, input logic [31:0] tlw,
                                              input logic [31:0] tcw, input logic [31:0] w3,
                                              input logic [11:0] base);
    lmp_result_t r;
    logic [10:0] crate_off;
    logic [12:0] mod_sum;
    r            = '0;
    crate_off    = {7'b0, h[11:8]} * CRATE_STEP;
    mod_sum      = {1'b0, base} + {2'b0, crate_off};
    r.kind       = kind;
    r.channel    = h[3:0];
    r.module_res = mod_sum[12] ? MODULE_MAX : mod_sum[11:0];
    r.pileup       = h[31];
    r.saturated    = h[30];
    r.virtual_chan = h[29];
    if (detail) begin
      r.event_time   = {tcw[15:0], tlw};
      r.cfd_time     = tcw[31:16];
      r.energy       = h[30] ? ENERGY_SAT : w3[15:0];
      r.trace_length = w3[31:16];
    end
    r.last = 1'b1;
    return r;
  endfunction

  // trace sample record
  function automatic lmp_result_t make_sample(input logic [15:0] s, input logic last_flag);
    lmp_result_t r;
    r        = '0;
    r.kind   = KIND_SAMPLE;
    r.sample = s;
    r.last   = last_flag;
    return r;
  endfunction

  // field slices of the current word
  assign words_dec = buffer_words_left - 32'd1;
  assign hl        = data_word[16:12];
  assign el        = data_word[28:17];
  assign tl_half   = data_word[31:17];
  assign len_sum   = {1'b0, tl_half} + {11'b0, header_words};
  assign idx_inc   = {1'b0, header_word_index} + 6'd1;

  // next state and results
  always_comb begin
    phase_next             = phase;
    buffer_words_left_next = buffer_words_left;
    base_module_next       = base_module;
    header_word_index_next = header_word_index;
    header_words_next      = header_words;
    event_words_left_next  = event_words_left;
    event_words_next       = event_words;
    header_first_word_next = header_first_word;
    time_low_word_next     = time_low_word;
    time_cfd_word_next     = time_cfd_word;
    trace_words_left_next  = trace_words_left;
    trace_left_now         = trace_words_left;
    hdr_stay               = 1'b1;
    push                   = '0;
    if (accept) begin
      case (phase)
        PH_MOD: begin
          base_module_next       = (|data_word[31:12]) ? MODULE_MAX : data_word[11:0];
          buffer_words_left_next = words_dec;
          phase_next             = PH_HDR0;
        end
        PH_HDR0: begin
          buffer_words_left_next = words_dec;
          header_first_word_next = data_word;
          header_words_next      = hl;
          event_words_next       = el;
          header_word_index_next = 5'd1;
          if (stats_header_length != 5'd0 && hl == stats_header_length) begin
            push.count = 2'd1;
            push.first = make_header(data_word, KIND_STATS, 1'b0, time_low_word,
                                     time_cfd_word, 32'd0, base_module);
            event_words_left_next = (el > 12'd1) ? el - 12'd1 : 12'd0;
            phase_next            = (el > 12'd1) ? PH_SKIP : PH_HDR0;
          end else if (!(hl inside {5'd4, 5'd8, 5'd12, 5'd16})) begin
            push.count = 2'd1;
            push.first = make_header(data_word, KIND_BAD_HDR, 1'b0, time_low_word,
                                     time_cfd_word, 32'd0, base_module);
            phase_next = PH_DRAIN;
          end else begin
            phase_next = PH_HDR;
          end
        end
        PH_HDR: begin
          buffer_words_left_next = words_dec;
          if (header_word_index == 5'd1) begin
            time_low_word_next = data_word;
          end
          if (header_word_index == 5'd2) begin
            time_cfd_word_next = data_word;
          end
          if (header_word_index == 5'd3) begin
            push.count = 2'd1;
            if (len_sum != {4'b0, event_words}) begin
              push.first = make_header(header_first_word, KIND_BAD_EVT, 1'b1, time_low_word,
                                       time_cfd_word, data_word, base_module);
              event_words_left_next = (event_words > 12'd4) ? event_words - 12'd4 : 12'd0;
              phase_next            = (event_words > 12'd4) ? PH_SKIP : PH_HDR0;
              hdr_stay              = 1'b0;
            end else begin
              push.first = make_header(header_first_word, KIND_EVENT, 1'b1, time_low_word,
                                       time_cfd_word, data_word, base_module);
              trace_words_left_next = tl_half;
              trace_left_now        = tl_half;
            end
          end
          // header end: go to trace or next event
          if (hdr_stay) begin
            if (header_word_index >= 5'd3 && idx_inc >= {1'b0, header_words}) begin
              phase_next = (trace_left_now != 15'd0) ? PH_TRACE : PH_HDR0;
            end else begin
              header_word_index_next = idx_inc[4:0];
            end
          end
        end
        PH_TRACE: begin
          buffer_words_left_next = words_dec;
          push.count             = 2'd2;
          push.first             = make_sample(data_word[15:0], 1'b0);
          push.second            = make_sample(data_word[31:16], 1'b1);
          trace_words_left_next  = trace_words_left - 15'd1;
          if (trace_words_left == 15'd1) begin
            phase_next = PH_HDR0;
          end
        end
        PH_SKIP: begin
          buffer_words_left_next = words_dec;
          event_words_left_next  = event_words_left - 12'd1;
          if (event_words_left == 12'd1) begin
            phase_next = PH_HDR0;
          end
        end
        PH_DRAIN: begin
          buffer_words_left_next = words_dec;
        end
        default: begin
          // buffer length word
          phase_next = PH_LEN;
          if (data_word == 32'd0) begin
            push.count = 2'd1;
            push.first = '0;
            push.first.kind = KIND_EMPTY;
            push.first.last = 1'b1;
          end else if (data_word != 32'd1) begin
            buffer_words_left_next = data_word - 32'd1;
            phase_next             = PH_MOD;
          end
        end
      endcase
      // end of buffer overrides everything
      if (phase != PH_LEN && words_dec == 32'd0) begin
        phase_next = PH_LEN;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_LEN;
      buffer_words_left <= '0;
      base_module       <= '0;
      header_word_index <= '0;
      header_words      <= '0;
      event_words_left  <= '0;
      event_words       <= '0;
      header_first_word <= '0;
      time_low_word     <= '0;
      time_cfd_word     <= '0;
      trace_words_left  <= '0;
    end else begin
      phase             <= phase_next;
      buffer_words_left <= buffer_words_left_next;
      base_module       <= base_module_next;
      header_word_index <= header_word_index_next;
      header_words      <= header_words_next;
      event_words_left  <= event_words_left_next;
      event_words       <= event_words_next;
      header_first_word <= header_first_word_next;
      time_low_word     <= time_low_word_next;
      time_cfd_word     <= time_cfd_word_next;
      trace_words_left  <= trace_words_left_next;
    end
  end

  // a trace word yields a low sample then a closing high sample
  a_trace_pair: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> (push.first.kind == KIND_SAMPLE && push.second.kind == KIND_SAMPLE
                            && !push.first.last && push.second.last))
    else $error("trace word results malformed");

  // a zero buffer length reports the empty-length error
  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_LEN && data_word == 32'd0
      |-> (push.count == 2'd1 && push.first.kind == KIND_EMPTY))
    else $error("empty buffer not reported");

  // the last word of a buffer returns to the length word
  a_buffer_end: assert property (@(posedge clk) disable iff (rst)
    accept && phase != PH_LEN && buffer_words_left == 32'd1 |=> phase == PH_LEN)
    else $error("buffer end missed");

endmodule

>>> design/lmp_result_queue.sv
// ----------------------------------------------------------------------------
// lmp_result_queue
// Four-entry result register queue. Takes up to two records per cycle from
// the parser and presents one record per transaction on the output side.
// ----------------------------------------------------------------------------
module lmp_result_queue
  import lmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  lmp_push_t   push,
  input  logic        pop,
  output lmp_result_t head,
  output logic        not_empty,
  output logic        has_room
);

  lmp_result_t       entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] wr_ptr_second;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign wr_ptr_second = wr_ptr + QPTR_W'(1);
  assign head          = entries[rd_ptr];
  assign not_empty     = count != '0;
  // room for a full pair of results
  assign has_room      = count <= QCNT_W'(QUEUE_DEPTH - 2);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count + QCNT_W'(push.count) - QCNT_W'(pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_second] <= push.second;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> (int'(count) + int'(push.count)) <= QUEUE_DEPTH)
    else $error("result queue overflow");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    pop && push.count == 2'd0 |=> int'(count) == int'($past(count)) - 1)
    else $error("result queue count not decremented");

endmodule

>>> design/list_mode_event_word_parser_top.sv
// ----------------------------------------------------------------------------
// list_mode_event_word_parser_top
// List-mode readout parser: splits buffers of 32-bit words into event
// records and trace samples, with one APB configuration register.
//
//   channel  dir  signals                          content
//   s_       in   s_tvalid s_tready s_tdata[31:0]   raw buffer word
//   m_       out  m_tvalid m_tready m_tdata m_tuser m_tlast   result record
//   apb      in   psel penable pwrite paddr pwdata prdata pready
//                 stats_header_length at 0x0
//
// One word is accepted per cycle while s_tready is high; its results are written
// into the result queue. Event and error words give one result, a trace word
// gives two, so the output side, one result per transaction, paces trace data.
// s_tready is low while the four-entry result queue holds more than two results.
// rst is synchronous: it clears the framing state, the queue and the register.
// ----------------------------------------------------------------------------
module list_mode_event_word_parser_top
  import lmp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [31:0]        s_tdata,   // [31:0] data_word
  output logic               m_tvalid,
  input  logic               m_tready,
  // [3:0] channel, [15:4] module_res, [63:16] event_time, [79:64] cfd_time,
  // [95:80] energy, [111:96] trace_length, [112] pileup, [113] saturated,
  // [114] virtual_chan, [130:115] sample, [135:131] zero
  output logic [TDATA_W-1:0] m_tdata,
  output logic [2:0]         m_tuser,   // [2:0] result_kind
  output logic               m_tlast,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [4:0]  stats_header_length;
  logic        accept;
  logic        has_room;
  lmp_push_t   push;
  lmp_result_t head;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      stats_header_length <= '0;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == REG_STATS_HEADER_LENGTH) begin
      stats_header_length <= pwdata[4:0];
    end
  end
  assign prdata = (paddr[2] == REG_STATS_HEADER_LENGTH) ? {27'b0, stats_header_length}
                                                        : 32'b0;

  // input transaction
  assign s_tready = has_room;
  assign accept   = s_tvalid && s_tready;

  lmp_parser u_parser (
    .clk                 (clk),
    .rst                 (rst),
    .accept              (accept),
    .data_word           (s_tdata),
    .stats_header_length (stats_header_length),
    .push                (push)
  );

  lmp_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (m_tvalid && m_tready),
    .head      (head),
    .not_empty (m_tvalid),
    .has_room  (has_room)
  );

  // output packing
  assign m_tuser = head.kind;
  assign m_tlast = head.last;
  assign m_tdata = {5'b0, head.sample, head.virtual_chan, head.saturated, head.pileup,
                    head.trace_length, head.energy, head.cfd_time, head.event_time,
                    head.module_res, head.channel};

endmodule

>>> tb/lmp_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lmp_result_checker
// Watches the word, result and register channels of the event word parser.
// Every accepted word runs through a parser of its own that produces the
// expected result records. Each accepted result is compared field by field
// with the oldest of them.
// ----------------------------------------------------------------------------
module lmp_result_checker
  import lmp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [31:0]        s_tdata,   // [31:0] data_word
  input  logic               m_tvalid,
  input  logic               m_tready,
  // [3:0] channel, [15:4] module_res, [63:16] event_time, [79:64] cfd_time,
  // [95:80] energy, [111:96] trace_length, [112] pileup, [113] saturated,
  // [114] virtual_chan, [130:115] sample, [135:131] zero
  input  logic [TDATA_W-1:0] m_tdata,
  input  logic [2:0]         m_tuser,   // [2:0] result_kind
  input  logic               m_tlast,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 errors,
  output int                 pending
);

  localparam logic [2:0] STATS_ADDR = {REG_STATS_HEADER_LENGTH, 2'b00};
  localparam int         PRINT_MAX  = 200;

  typedef enum logic [2:0] {
    WAIT_LEN,
    WAIT_MODULE,
    WAIT_HDR0,
    IN_HDR,
    IN_TRACE,
    IN_SKIP,
    IN_DRAIN
  } parse_phase_t;

  // parser copy and register copy
  parse_phase_t ph;
  logic [31:0]  words_left;
  logic [11:0]  base_module;
  logic [4:0]   hdr_index;
  logic [4:0]   hdr_words;
  logic [11:0]  evt_left;
  logic [11:0]  evt_words;
  logic [31:0]  hdr_first;
  logic [31:0]  time_low;
  logic [31:0]  time_cfd;
  logic [14:0]  trace_left;
  logic [4:0]   stats_len;

  lmp_result_t expected_results[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report(input string msg);
    errors++;
    if (errors <= PRINT_MAX)
      $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [47:0] got_v,
                             input logic [47:0] want_v);
    if (got_v !== want_v)
      report($sformatf("%s is %0h, expected %0h", name, got_v, want_v));
  endtask

  // record for event, stats and bad-length kinds
  function automatic lmp_result_t header_record(input lmp_kind_t kind, input bit detail,
                                                input logic [31:0] w3);
    lmp_result_t r;
    logic [31:0] m;
    r = '0;
    m = 32'(base_module) + 32'(CRATE_STEP) * 32'(hdr_first[11:8]);
    r.kind         = kind;
    r.channel      = hdr_first[3:0];
    r.module_res   = (m > 32'(MODULE_MAX)) ? MODULE_MAX : m[11:0];
    r.pileup       = hdr_first[31];
    r.saturated    = hdr_first[30];
    r.virtual_chan = hdr_first[29];
    if (detail) begin
      r.event_time   = {time_cfd[15:0], time_low};
      r.cfd_time     = time_cfd[31:16];
      r.energy       = hdr_first[30] ? ENERGY_SAT : w3[15:0];
      r.trace_length = w3[31:16];
    end
    r.last = 1'b1;
    return r;
  endfunction

  function automatic lmp_result_t sample_record(input logic [15:0] s, input logic is_last);
    lmp_result_t r;
    r = '0;
    r.kind   = KIND_SAMPLE;
    r.sample = s;
    r.last   = is_last;
    return r;
  endfunction

  // append one expected result
  task automatic expect_result(input lmp_result_t r);
    expected_results = {expected_results, r};
  endtask

  task automatic reset_parser();
    ph          = WAIT_LEN;
    words_left  = '0;
    base_module = '0;
    hdr_index   = '0;
    hdr_words   = '0;
    evt_left    = '0;
    evt_words   = '0;
    hdr_first   = '0;
    time_low    = '0;
    time_cfd    = '0;
    trace_left  = '0;
    stats_len   = '0;
  endtask

  // advance the parser by one buffer word and queue what it yields
  task automatic parse_word(input logic [31:0] w);
    lmp_result_t r;
    logic [4:0]  hl;
    logic [11:0] el;
    logic [15:0] tl;
    logic [4:0]  idx;
    if (ph == WAIT_MODULE) begin
      base_module = (w > 32'(MODULE_MAX)) ? MODULE_MAX : w[11:0];
      words_left  = words_left - 1;
      ph          = (words_left == 0) ? WAIT_LEN : WAIT_HDR0;
      return;
    end
    if (ph == WAIT_LEN) begin
      if (w == 0) begin
        r = '0;
        r.kind = KIND_EMPTY;
        r.last = 1'b1;
        expect_result(r);
      end else if (w >= 2) begin
        words_left = w - 1;
        ph         = WAIT_MODULE;
      end
      return;
    end

    words_left = words_left - 1;
    case (ph)
      WAIT_HDR0: begin
        hl        = w[16:12];
        el        = w[28:17];
        hdr_first = w;
        hdr_words = hl;
        evt_words = el;
        hdr_index = 5'd1;
        if (stats_len != 0 && hl == stats_len) begin
          expect_result(header_record(KIND_STATS, 1'b0, '0));
          evt_left = (el > 1) ? el - 12'd1 : 12'd0;
          ph       = (evt_left != 0) ? IN_SKIP : WAIT_HDR0;
        end else if (hl != 5'd4 && hl != 5'd8 && hl != 5'd12 && hl != 5'd16) begin
          expect_result(header_record(KIND_BAD_HDR, 1'b0, '0));
          ph = IN_DRAIN;
        end else begin
          ph = IN_HDR;
        end
      end
      IN_HDR: begin
        idx = hdr_index;
        if (idx == 5'd1) begin
          time_low = w;
        end else if (idx == 5'd2) begin
          time_cfd = w;
        end else if (idx == 5'd3) begin
          tl = w[31:16];
          if (32'(tl >> 1) + 32'(hdr_words) != 32'(evt_words)) begin
            expect_result(header_record(KIND_BAD_EVT, 1'b1, w));
            evt_left = (evt_words > 4) ? evt_words - 12'd4 : 12'd0;
            ph       = (evt_left != 0) ? IN_SKIP : WAIT_HDR0;
          end else begin
            expect_result(header_record(KIND_EVENT, 1'b1, w));
            trace_left = tl[15:1];
          end
        end
        // remaining header words (qdc, sums) are only counted
        if (ph == IN_HDR) begin
          if (idx >= 5'd3 && 32'(idx) + 1 >= 32'(hdr_words))
            ph = (trace_left != 0) ? IN_TRACE : WAIT_HDR0;
          else
            hdr_index = idx + 5'd1;
        end
      end
      IN_TRACE: begin
        expect_result(sample_record(w[15:0], 1'b0));
        expect_result(sample_record(w[31:16], 1'b1));
        trace_left = trace_left - 15'd1;
        if (trace_left == 0)
          ph = WAIT_HDR0;
      end
      IN_SKIP: begin
        evt_left = evt_left - 12'd1;
        if (evt_left == 0)
          ph = WAIT_HDR0;
      end
      default: ;
    endcase

    // the buffer end overrides everything
    if (words_left == 0)
      ph = WAIT_LEN;
  endtask

  task automatic compare_result(input lmp_result_t got, input lmp_result_t want,
                                input logic [4:0] pad);
    check_field("result_kind", got.kind, want.kind);
    check_field("channel", got.channel, want.channel);
    check_field("module_res", got.module_res, want.module_res);
    check_field("event_time", got.event_time, want.event_time);
    check_field("cfd_time", got.cfd_time, want.cfd_time);
    check_field("energy", got.energy, want.energy);
    check_field("trace_length", got.trace_length, want.trace_length);
    check_field("pileup", got.pileup, want.pileup);
    check_field("saturated", got.saturated, want.saturated);
    check_field("virtual_chan", got.virtual_chan, want.virtual_chan);
    check_field("sample", got.sample, want.sample);
    check_field("last", got.last, want.last);
    check_field("tdata padding", pad, '0);
  endtask

  // channel monitor: register writes, word transactions, result transactions
  always @(posedge clk) begin : monitor
    lmp_result_t got;
    if (rst) begin
      reset_parser();
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == STATS_ADDR)
        stats_len = pwdata[4:0];
      if (s_tvalid && s_tready)
        parse_word(s_tdata);
      if (m_tvalid && m_tready) begin
        got.kind         = lmp_kind_t'(m_tuser);
        got.channel      = m_tdata[3:0];
        got.module_res   = m_tdata[15:4];
        got.event_time   = m_tdata[63:16];
        got.cfd_time     = m_tdata[79:64];
        got.energy       = m_tdata[95:80];
        got.trace_length = m_tdata[111:96];
        got.pileup       = m_tdata[112];
        got.saturated    = m_tdata[113];
        got.virtual_chan = m_tdata[114];
        got.sample       = m_tdata[130:115];
        got.last         = m_tlast;
        if (expected_results.size() == 0)
          report($sformatf("result of kind %0d with none expected", m_tuser));
        else
          compare_result(got, expected_results.pop_front(), m_tdata[135:131]);
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the list-mode event word parser. Streams readout buffers of
// well-formed events, statistics blocks, broken headers, cut buffers and
// noise, with random gaps on both stream sides, and switches the statistics
// header length between phases. Checking is done by lmp_result_checker.
// ----------------------------------------------------------------------------
module testbench;
  import lmp_pkg::*;

  localparam logic [2:0] STATS_ADDR   = {REG_STATS_HEADER_LENGTH, 2'b00};
  localparam int         RANDOM_WORDS = 900;
  localparam int         QUIET_TAIL   = 120;
  localparam int         CFG_INTERVAL = 150;

  logic               clk = 1'b0;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [31:0]        s_tdata;
  logic               m_tvalid;
  logic               m_tready;
  logic [TDATA_W-1:0] m_tdata;
  logic [2:0]         m_tuser;
  logic               m_tlast;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 errors;
  int                 pending;

  int          words_sent;
  bit          idle_en;
  bit          gaps_on;
  logic [4:0]  stats_len;
  logic [31:0] frame_q[$];

  list_mode_event_word_parser_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  lmp_result_checker i_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .pready   (pready),
    .errors   (errors),
    .pending  (pending)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // result side backpressure: stall bursts between ready stretches
  initial begin
    m_tready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (idle_en && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      m_tready <= 1'b1;
      if ($urandom_range(0, 7) == 0)
        repeat (200) @(negedge clk);
      else
        repeat ($urandom_range(1, 24)) @(negedge clk);
    end
  end

  // one word transaction, with an optional gap before it
  task automatic send_word(input logic [31:0] w);
    @(negedge clk);
    if (gaps_on && idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  // stop sending and let every expected result come out
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_stats(input logic [4:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= STATS_ADDR;
    pwdata  <= {27'($urandom), v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    stats_len = v;
  endtask

  function automatic logic [31:0] random_module();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return $urandom_range(0, 300);
    else if (r < 85)
      return $urandom;
    else
      return $urandom_range(4090, 4100);
  endfunction

  // append one word to the buffer content
  task automatic queue_word(input logic [31:0] w);
    frame_q = {frame_q, w};
  endtask

  // event: header words 0..3, extra header words, trace words
  task automatic add_event(input logic [4:0] hl, input logic [15:0] tl,
                           input logic [11:0] el, input logic [2:0] flags,
                           input logic [11:0] ident, input logic [15:0] energy);
    int unsigned tail;
    queue_word({flags, el, hl, ident});
    queue_word($urandom);
    queue_word($urandom);
    queue_word({tl, energy});
    if (32'(tl >> 1) + 32'(hl) == 32'(el))
      tail = 32'(hl) - 4 + 32'(tl >> 1);
    else
      tail = (el > 4) ? 32'(el) - 4 : 0;
    repeat (tail) queue_word($urandom);
  endtask

  task automatic add_stats(input logic [11:0] el);
    queue_word({3'($urandom), el, stats_len, 12'($urandom)});
    repeat ((el > 1) ? 32'(el) - 1 : 0) queue_word($urandom);
  endtask

  // a header length that is neither valid nor the statistics marker
  task automatic add_bad_header(input logic [4:0] hl, input int drained);
    queue_word({3'($urandom), 12'($urandom_range(0, 12)), hl, 12'($urandom)});
    repeat (drained) queue_word($urandom);
  endtask

  // length word, module word, then the queued content, optionally cut short
  task automatic send_buffer(input bit cut, input logic [31:0] module_word);
    int unsigned total;
    total = frame_q.size() + 2;
    if (cut && total > 3)
      total = $urandom_range(3, total - 1);
    send_word(total);
    send_word(module_word);
    for (int i = 0; i < total - 2; i++)
      send_word(frame_q[i]);
    frame_q.delete();
  endtask

  function automatic logic [4:0] pick_header_length();
    logic [4:0] hl;
    int r;
    do begin
      r = $urandom_range(0, 9);
      if (r < 6)
        hl = 5'd4;
      else if (r < 8)
        hl = 5'd8;
      else if (r < 9)
        hl = 5'd12;
      else
        hl = 5'd16;
    end while (hl == stats_len);
    return hl;
  endfunction

  function automatic logic [15:0] pick_energy();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0)
      return 16'hFFFF;
    else if (r == 1)
      return 16'h0000;
    else
      return 16'($urandom);
  endfunction

  // main sequence
  initial begin
    int stop_at;
    int next_cfg_at;
    int cfg_n;
    int r;
    int nev;
    logic [4:0]  hl;
    logic [15:0] tl;
    logic [11:0] el;

    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    words_sent = 0;
    idle_en    = 1'b1;
    gaps_on    = 1'b1;
    stats_len  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty buffer, one-word and two-word buffers
    send_word(32'd0);
    send_word(32'd1);
    send_word(32'd2);
    send_word(random_module());

    // saturated module, all flags with saturated energy, odd trace length,
    // bad event length with full trace length, bad header length then drain
    add_event(5'd4, 16'd4, 12'd6, 3'b111, 12'hFFF, 16'hFFFF);
    add_event(5'd4, 16'd3, 12'd5, 3'b000, 12'h000, 16'h1234);
    add_event(5'd4, 16'hFFFF, 12'd7, 3'b101, 12'hA5C, 16'h8001);
    add_bad_header(5'd0, 2);
    send_buffer(1'b0, 32'hFFFF_FFFF);

    // statistics blocks of length 0, 1 and the largest, cut by buffer end
    wait_drained();
    write_stats(5'd31);
    add_stats(12'd0);
    add_stats(12'd1);
    queue_word({3'($urandom), 12'hFFF, stats_len, 12'($urandom)});
    repeat (6) queue_word($urandom);
    send_buffer(1'b0, 32'd0);

    // random buffers
    stop_at     = words_sent + RANDOM_WORDS;
    next_cfg_at = words_sent + CFG_INTERVAL;
    cfg_n       = 0;
    while (words_sent < stop_at) begin
      idle_en = (words_sent + QUIET_TAIL < stop_at);
      gaps_on = ($urandom_range(0, 2) != 0);

      if (words_sent >= next_cfg_at) begin
        wait_drained();
        case (cfg_n % 4)
          0: write_stats(5'd0);
          1: write_stats(5'd31);
          2: write_stats(5'd8);
          default: write_stats(5'($urandom_range(1, 31)));
        endcase
        cfg_n++;
        next_cfg_at = words_sent + CFG_INTERVAL;
      end

      r = $urandom_range(0, 99);
      if (r < 6) begin
        // tiny buffers
        r = $urandom_range(0, 2);
        send_word(r);
        if (r == 2)
          send_word(random_module());
      end else if (r < 12) begin
        // noise content
        repeat ($urandom_range(1, 10)) queue_word($urandom);
        send_buffer(1'b0, random_module());
      end else begin
        nev = $urandom_range(1, 4);
        repeat (nev) begin
          r = $urandom_range(0, 99);
          if (r < 75 || (r >= 88 && stats_len == 0)) begin
            hl = pick_header_length();
            r  = $urandom_range(0, 99);
            if (r < 85)
              tl = 16'(2 * $urandom_range(0, 6));
            else if (r < 97)
              tl = 16'($urandom_range(0, 25));
            else
              tl = 16'($urandom_range(100, 300));
            add_event(hl, tl, 12'(32'(hl) + 32'(tl >> 1)), 3'($urandom), 12'($urandom),
                      pick_energy());
          end else if (r < 88) begin
            hl = pick_header_length();
            tl = ($urandom_range(0, 9) < 3) ? 16'($urandom) : 16'($urandom_range(0, 12));
            el = 12'($urandom_range(0, 12));
            if (32'(el) == 32'(hl) + 32'(tl >> 1))
              el = el + 12'd1;
            add_event(hl, tl, el, 3'($urandom), 12'($urandom), pick_energy());
          end else begin
            add_stats(12'($urandom_range(0, 8)));
          end
        end
        if ($urandom_range(0, 9) == 0) begin
          do hl = 5'($urandom);
          while (hl == 5'd4 || hl == 5'd8 || hl == 5'd12 || hl == 5'd16 ||
                 (stats_len != 0 && hl == stats_len));
          add_bad_header(hl, $urandom_range(0, 3));
        end
        send_buffer($urandom_range(0, 9) == 0, random_module());
      end

      // occasional full drain of the output side
      if ($urandom_range(0, 30) == 0)
        wait_drained();
    end

    wait_drained();
    repeat (16) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
